// File: src/spq_pkg.sv
package spq_pkg;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  typedef struct packed {
    logic [7:0]  prio;
    logic [15:0] requester;
    logic [15:0] title;
  } entry_t;

  typedef struct packed {
    logic ins;
    logic rem;
  } cell_ctrl_t;

endpackage

// File: src/spq_cell.sv
module spq_cell (
  input  logic               clk,
  input  spq_pkg::cell_ctrl_t ctrl,
  input  spq_pkg::entry_t    new_entry,
  input  logic               occupied,
  input  logic               left_keep,
  input  spq_pkg::entry_t    left_entry,
  input  spq_pkg::entry_t    right_entry,
  output logic               keep,
  output spq_pkg::entry_t    entry
);
  import spq_pkg::*;

  entry_t entry_next;

  assign keep = occupied && (entry.prio <= new_entry.prio);

  always_comb begin
    entry_next = entry;
    priority if (ctrl.ins) begin
      priority if (keep) begin
        entry_next = entry;
      end else if (left_keep) begin
        entry_next = new_entry;
      end else begin
        entry_next = left_entry;
      end
    end else if (ctrl.rem) begin
      entry_next = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

// File: src/stable_priority_queue.sv
// A result is registered and presented in the cycle after its request beat is accepted.
// Throughput: one request per cycle while the output is not stalled; every cell of the
// slot row compares its own priority with the request and loads itself, its neighbor
// or the new entry in that same cycle, so the row update sets the rate.
// Reset clears the entry count and the output valid flag; slot contents are not cleared.
module stable_priority_queue #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        op,
  input  logic [7:0]  priority_req,
  input  logic [15:0] requester_ref,
  input  logic [15:0] title_ref,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [7:0]  out_priority,
  output logic [15:0] out_requester,
  output logic [15:0] out_title,
  output logic [4:0]  occupancy
);
  import spq_pkg::*;

  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(QUEUE_DEPTH);

  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic          accept;
  logic          is_full;
  logic          is_empty;
  cell_ctrl_t    ctrl;
  entry_t        new_entry;
  entry_t        cell_entry [QUEUE_DEPTH];
  logic          cell_keep  [QUEUE_DEPTH];
  logic [CW+4:0] count_ext;
  logic [1:0]    status_next;

  assign in_ready  = !out_valid || out_ready;
  assign accept    = in_valid && in_ready;
  assign is_full   = (count == FULL_COUNT);
  assign is_empty  = (count == '0);
  assign new_entry = '{prio: priority_req, requester: requester_ref, title: title_ref};

  assign ctrl.ins = accept && (op == OP_INSERT) && !is_full;
  assign ctrl.rem = accept && (op == OP_REMOVE) && !is_empty;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic   left_keep;
    entry_t left_entry;
    entry_t right_entry;

    if (i == 0) begin : g_head
      assign left_keep  = 1'b1;
      assign left_entry = new_entry;
    end else begin : g_body
      assign left_keep  = cell_keep[i-1];
      assign left_entry = cell_entry[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign right_entry = cell_entry[i];
    end else begin : g_inner
      assign right_entry = cell_entry[i+1];
    end

    spq_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .new_entry   (new_entry),
      .occupied    (CW'(i) < count),
      .left_keep   (left_keep),
      .left_entry  (left_entry),
      .right_entry (right_entry),
      .keep        (cell_keep[i]),
      .entry       (cell_entry[i])
    );
  end

  always_comb begin
    count_next = count;
    priority if (ctrl.ins) begin
      count_next = count + 1'b1;
    end else if (ctrl.rem) begin
      count_next = count - 1'b1;
    end
  end

  always_comb begin
    unique case (op)
      OP_INSERT: status_next = is_full ? STATUS_FULL : STATUS_OK;
      OP_REMOVE: status_next = is_empty ? STATUS_EMPTY : STATUS_OK;
      default:   status_next = STATUS_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status <= status_next;
      if (ctrl.rem) begin
        out_priority  <= cell_entry[0].prio;
        out_requester <= cell_entry[0].requester;
        out_title     <= cell_entry[0].title;
      end else begin
        out_priority  <= '0;
        out_requester <= '0;
        out_title     <= '0;
      end
    end
  end

  assign count_ext = {5'b0, count};
  assign occupancy = count_ext[4:0];

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_COUNT)
    else $error("entry count above capacity");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == STATUS_FULL) |-> is_full)
    else $error("full status while queue not full");

  a_empty_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == STATUS_EMPTY) |-> is_empty)
    else $error("empty status while queue holds entries");

  a_insert_count: assert property (@(posedge clk) disable iff (rst)
    ctrl.ins |=> count == $past(count) + 1'b1)
    else $error("insert did not advance count");

endmodule

// File: tb/stable_priority_queue_tb.sv
`timescale 1ns / 1ps

module stable_priority_queue_tb;
  import spq_pkg::*;

  localparam int DEPTH = 16;

  typedef struct {
    logic        op;
    logic [7:0]  prio;
    logic [15:0] requester;
    logic [15:0] title;
  } request_t;

  typedef struct {
    logic [1:0]  status;
    logic [7:0]  prio;
    logic [15:0] requester;
    logic [15:0] title;
    logic [4:0]  occupancy;
  } removal_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        op = OP_INSERT;
  logic [7:0]  priority_req = 8'd0;
  logic [15:0] requester_ref = 16'd0;
  logic [15:0] title_ref = 16'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  status;
  logic [7:0]  out_priority;
  logic [15:0] out_requester;
  logic [15:0] out_title;
  logic [4:0]  occupancy;

  request_t pending[$];
  removal_t expected_q[$];

  logic [7:0]  shadow_prio[DEPTH];
  logic [15:0] shadow_requester[DEPTH];
  logic [15:0] shadow_title[DEPTH];
  int shadow_count = 0;

  int mismatches = 0;
  int beats_in = 0;
  int beats_out = 0;
  int n_insert = 0;
  int n_remove = 0;
  int n_full = 0;
  int n_empty = 0;
  int peak_fill = 0;

  logic in_beat = 1'b0;
  logic hold_off = 1'b0;
  int burst_left = 0;
  int gap_left = 0;
  int rx_cycle = 0;

  stable_priority_queue #(.QUEUE_DEPTH(DEPTH)) uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .op(op),
    .priority_req(priority_req),
    .requester_ref(requester_ref),
    .title_ref(title_ref),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status(status),
    .out_priority(out_priority),
    .out_requester(out_requester),
    .out_title(out_title),
    .occupancy(occupancy)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  task automatic report_mismatch(string field, int unsigned got, int unsigned want);
    if (mismatches < 40)
      $display("MISMATCH at result %0d: %s got %0h, want %0h", beats_out, field, got, want);
    mismatches++;
  endtask

  task automatic queue_request(logic o, logic [7:0] p, logic [15:0] r, logic [15:0] t);
    request_t item;
    item.op = o;
    item.prio = p;
    item.requester = r;
    item.title = t;
    pending.push_back(item);
  endtask

  task automatic apply_request(logic o, logic [7:0] p, logic [15:0] r, logic [15:0] t);
    removal_t res;
    int pos;
    res.status = STATUS_OK;
    res.prio = 8'd0;
    res.requester = 16'd0;
    res.title = 16'd0;
    if (o == OP_INSERT) begin
      n_insert++;
      if (shadow_count >= DEPTH) begin
        res.status = STATUS_FULL;
        n_full++;
      end else begin
        pos = 0;
        while (pos < shadow_count && shadow_prio[pos] <= p) pos++;
        for (int i = shadow_count; i > pos; i--) begin
          shadow_prio[i] = shadow_prio[i-1];
          shadow_requester[i] = shadow_requester[i-1];
          shadow_title[i] = shadow_title[i-1];
        end
        shadow_prio[pos] = p;
        shadow_requester[pos] = r;
        shadow_title[pos] = t;
        shadow_count++;
      end
    end else begin
      n_remove++;
      if (shadow_count == 0) begin
        res.status = STATUS_EMPTY;
        n_empty++;
      end else begin
        res.prio = shadow_prio[0];
        res.requester = shadow_requester[0];
        res.title = shadow_title[0];
        for (int i = 1; i < shadow_count; i++) begin
          shadow_prio[i-1] = shadow_prio[i];
          shadow_requester[i-1] = shadow_requester[i];
          shadow_title[i-1] = shadow_title[i];
        end
        shadow_count--;
      end
    end
    if (shadow_count > peak_fill) peak_fill = shadow_count;
    res.occupancy = 5'(shadow_count);
    expected_q.push_back(res);
  endtask

  // driver: bursts of beats separated by random gaps
  always @(negedge clk) begin
    logic drive;
    request_t item;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      drive = in_valid && !in_beat;
      if (!drive) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending.size() != 0) begin
          item = pending.pop_front();
          drive = 1'b1;
          op <= item.op;
          priority_req <= item.prio;
          requester_ref <= item.requester;
          title_ref <= item.title;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(40, 120)
                                                   : $urandom_range(1, 16);
            gap_left = $urandom_range(0, 7) == 0 ? $urandom_range(10, 30)
                                                 : $urandom_range(0, 4);
          end
        end
      end
      in_valid <= drive;
    end
  end

  // receiver: stall pattern steps through four modes in turn
  always @(negedge clk) begin
    logic rdy;
    rx_cycle++;
    case ((rx_cycle / 97) % 4)
      0: rdy = 1'b1;
      1: rdy = $urandom_range(0, 1) == 0;
      2: rdy = $urandom_range(0, 3) == 0;
      default: rdy = (rx_cycle % 7) < 3;
    endcase
    out_ready <= rdy && !hold_off;
  end

  // hold the output off for long stretches while the sender keeps offering beats
  initial begin
    wait (beats_in >= 400);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (150) @(posedge clk);
    hold_off <= 1'b0;
    wait (beats_in >= 1100);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (200) @(posedge clk);
    hold_off <= 1'b0;
  end

  // monitor: check each result beat, then predict from each request beat
  always @(posedge clk) begin
    removal_t want;
    if (rst) begin
      in_beat <= 1'b0;
    end else begin
      in_beat <= in_valid && in_ready;
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected result, status", 32'(status), 0);
        end else begin
          want = expected_q.pop_front();
          if (status !== want.status)
            report_mismatch("status", 32'(status), 32'(want.status));
          if (out_priority !== want.prio)
            report_mismatch("out_priority", 32'(out_priority), 32'(want.prio));
          if (out_requester !== want.requester)
            report_mismatch("out_requester", 32'(out_requester), 32'(want.requester));
          if (out_title !== want.title)
            report_mismatch("out_title", 32'(out_title), 32'(want.title));
          if (occupancy !== want.occupancy)
            report_mismatch("occupancy", 32'(occupancy), 32'(want.occupancy));
        end
        beats_out++;
      end
      if (in_valid && in_ready) begin
        beats_in++;
        apply_request(op, priority_req, requester_ref, title_ref);
      end
    end
  end

  initial begin
    logic [7:0] fill_prio[DEPTH];
    int count;
    int seg_len;
    int ins_pct;
    int pri_mode;
    logic [7:0] p;
    fill_prio = '{8'd255, 8'd0, 8'd128, 8'd128, 8'd128, 8'd0, 8'd255, 8'd7,
                  8'd128, 8'd1, 8'd254, 8'd0, 8'd64, 8'd128, 8'd200, 8'd3};

    // remove on empty, fill with ties and extremes, overflow, then drain a few
    queue_request(OP_REMOVE, 8'hFF, 16'hFFFF, 16'hFFFF);
    queue_request(OP_INSERT, fill_prio[0], 16'hFFFF, 16'hFFFF);
    queue_request(OP_INSERT, fill_prio[1], 16'h0000, 16'h0000);
    for (int k = 2; k < DEPTH; k++)
      queue_request(OP_INSERT, fill_prio[k], 16'(k * 16'h1111), 16'(~(k * 16'h0101)));
    queue_request(OP_INSERT, 8'd0, 16'hFFFF, 16'hFFFF);
    repeat (4) queue_request(OP_REMOVE, 8'd0, 16'h0000, 16'h0000);

    count = 0;
    while (count < 1550) begin
      seg_len = $urandom_range(10, 60);
      case ($urandom_range(0, 3))
        0: ins_pct = 15;
        1: ins_pct = 50;
        2: ins_pct = 80;
        default: ins_pct = 97;
      endcase
      pri_mode = $urandom_range(0, 3);
      for (int k = 0; k < seg_len; k++) begin
        case (pri_mode)
          0: p = 8'($urandom_range(0, 255));
          1: p = 8'($urandom_range(0, 3));
          2: p = $urandom_range(0, 1) ? 8'hFF : 8'h00;
          default: p = 8'(100 + $urandom_range(0, 7));
        endcase
        queue_request($urandom_range(0, 99) < ins_pct ? OP_INSERT : OP_REMOVE,
                      p, 16'($urandom), 16'($urandom));
        count++;
      end
    end

    repeat (12) @(negedge clk);
    rst <= 1'b0;

    while (pending.size() != 0 || in_valid || expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (expected_q.size() != 0) report_mismatch("results left over", expected_q.size(), 0);

    $display("Ran %0d inserts (%0d dropped on full) and %0d removes (%0d on empty).",
             n_insert, n_full, n_remove, n_empty);
    $display("Checked %0d result beats under bursty input and output stalls, peak fill %0d.",
             beats_out, peak_fill);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Timeout after %0d request beats and %0d result beats", beats_in, beats_out);
    $display("Mismatches found");
    $finish;
  end

endmodule
